// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define PLID_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("assertion failed");

// Consequence checked by non-overlapping implication from the antecedent.
`define PLID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/plid_pkg.sv =====
// Shared types, sizes and helpers for the positional list block.
// No dependencies.
package plid_pkg;

    localparam int DEPTH  = 64;
    localparam int WIDTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int KIND_W = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - VAL_W - POS_W - STAT_W;

    typedef logic [WIDTH-1:0] word_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_PLACE,
        ST_DONE
    } state_t;

    typedef struct packed {
        kind_t                    kind;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        logic [POS_W-1:0]         count;
        status_t                  status;
    } res_t;

    function automatic logic [VAL_W-1:0] word_to_field(word_t w);
        logic signed [63:0] t;
        t = 64'(signed'(w));
        return t[VAL_W-1:0];
    endfunction

    function automatic word_t field_to_word(logic signed [VAL_W-1:0] v);
        logic signed [63:0] t;
        t = 64'(v);
        return t[WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/core/positional_list_insert_delete.sv =====
// Top level; depends on plid_pkg, plid_engine and assert_macros.svh.
// Insert sweeps the entries from position to the end, then places the value; append places it
// directly; delete sweeps from position to the end; read fetches one entry; a refused request goes
// straight to the result. The store sweep moves one entry per cycle. One request in work at a time:
// the next is taken once the beat is in the output register, where the beat may wait meanwhile.
// Reset: synchronous, active low; clears the count and all handshake state. Store is not reset.
`include "assert_macros.svh"

module positional_list_insert_delete (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [plid_pkg::S_TDATA_W-1:0]  s_tdata,  // position[6:0], value[38:7], zero
    input  logic [plid_pkg::KIND_W-1:0]     s_tuser,  // kind[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [plid_pkg::M_TDATA_W-1:0]  m_tdata   // read_value[31:0], count[38:32],
                                                      // status[40:39], zero
);

    plid_pkg::req_t req;
    plid_pkg::res_t res;
    logic           res_valid;
    logic           res_take;

    logic           m_tvalid_reg, m_tvalid_next;
    plid_pkg::res_t m_res_reg, m_res_next;

    assign req.kind     = plid_pkg::kind_t'(s_tuser);
    assign req.position = s_tdata[plid_pkg::POS_W-1:0];
    assign req.value    = s_tdata[plid_pkg::POS_W+plid_pkg::VAL_W-1:plid_pkg::POS_W];

    plid_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output register
    always_comb begin
        res_take      = res_valid && (!m_tvalid_reg || m_tready);
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_take) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{plid_pkg::M_PAD_W{1'b0}}, m_res_reg.status, m_res_reg.count,
                       m_res_reg.read_value};

    `PLID_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `PLID_ASSERT(a_full_means_depth,
        !(m_tvalid_reg && m_res_reg.status == plid_pkg::STATUS_FULL) ||
        (m_res_reg.count == plid_pkg::POS_W'(plid_pkg::DEPTH)))
    `PLID_ASSERT(a_refused_reads_zero,
        !(m_tvalid_reg && m_res_reg.status != plid_pkg::STATUS_OK) ||
        (m_res_reg.read_value == '0))
    `PLID_ASSERT(a_count_bound,
        !m_tvalid_reg ||
        (plid_pkg::CMP_W'(m_res_reg.count) <= plid_pkg::CMP_W'(plid_pkg::DEPTH)))

endmodule

// ===== rtl/core/plid_engine.sv =====
// List store and sequencer: a sweep that reads one entry per cycle and writes it back on insert/delete.
// Depends on plid_pkg.
module plid_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            req_valid,
    output logic            req_ready,
    input  plid_pkg::req_t  req,
    output logic            res_valid,
    input  logic            res_take,
    output plid_pkg::res_t  res
);

    plid_pkg::word_t mem [plid_pkg::DEPTH];

    plid_pkg::state_t                state_reg, state_next;
    plid_pkg::kind_t                 op_kind_reg, op_kind_next;
    logic [plid_pkg::CNT_W-1:0]      op_pos_reg, op_pos_next;
    plid_pkg::word_t                 op_word_reg, op_word_next;
    logic [plid_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [plid_pkg::CNT_W-1:0]      ptr_reg, ptr_next;
    logic [plid_pkg::CNT_W-1:0]      left_reg, left_next;
    logic                            pend_reg, pend_next;
    logic                            pend_cap_reg, pend_cap_next;
    logic [plid_pkg::ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [plid_pkg::VAL_W-1:0]      res_value_reg, res_value_next;
    plid_pkg::status_t               res_status_reg, res_status_next;
    plid_pkg::word_t                 rd_data_reg;

    logic                            rd_en, wr_en;
    logic [plid_pkg::ADDR_W-1:0]     rd_addr, wr_addr;
    plid_pkg::word_t                 wr_data;

    logic [plid_pkg::CMP_W-1:0]      pos_ext, cnt_ext;
    plid_pkg::status_t               req_status;
    logic                            req_bad;

    assign pos_ext = plid_pkg::CMP_W'(req.position);
    assign cnt_ext = plid_pkg::CMP_W'(count_reg);

    always_comb begin
        req_status = plid_pkg::STATUS_OK;
        case (req.kind)
            plid_pkg::KIND_INSERT: begin
                if (cnt_ext == plid_pkg::CMP_W'(plid_pkg::DEPTH)) begin
                    req_status = plid_pkg::STATUS_FULL;
                end else if (pos_ext > cnt_ext) begin
                    req_status = plid_pkg::STATUS_RANGE;
                end
            end
            plid_pkg::KIND_DELETE, plid_pkg::KIND_READ: begin
                if (pos_ext >= cnt_ext) begin
                    req_status = plid_pkg::STATUS_RANGE;
                end
            end
            default: req_status = plid_pkg::STATUS_RANGE;
        endcase
        req_bad = (req_status != plid_pkg::STATUS_OK);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            plid_pkg::ST_IDLE: begin
                if (req_valid) begin
                    if (req_bad) begin
                        state_next = plid_pkg::ST_DONE;
                    end else if (req.kind == plid_pkg::KIND_INSERT && pos_ext == cnt_ext) begin
                        state_next = plid_pkg::ST_PLACE;
                    end else begin
                        state_next = plid_pkg::ST_SWEEP;
                    end
                end
            end
            plid_pkg::ST_SWEEP: begin
                if (left_reg == '0) begin
                    state_next = (op_kind_reg == plid_pkg::KIND_INSERT) ?
                                 plid_pkg::ST_PLACE : plid_pkg::ST_DONE;
                end
            end
            plid_pkg::ST_PLACE: state_next = plid_pkg::ST_DONE;
            plid_pkg::ST_DONE: begin
                if (res_take) begin
                    state_next = plid_pkg::ST_IDLE;
                end
            end
            default: state_next = plid_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        req_ready = (state_reg == plid_pkg::ST_IDLE);
        res_valid = (state_reg == plid_pkg::ST_DONE);
    end

    assign res.read_value = res_value_reg;
    assign res.count      = plid_pkg::POS_W'(count_reg);
    assign res.status     = res_status_reg;

    // datapath and store access
    always_comb begin
        op_kind_next    = op_kind_reg;
        op_pos_next     = op_pos_reg;
        op_word_next    = op_word_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        pend_next       = pend_reg;
        pend_cap_next   = pend_cap_reg;
        pend_addr_next  = pend_addr_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        rd_addr         = ptr_reg[plid_pkg::ADDR_W-1:0];
        wr_addr         = pend_addr_reg;
        wr_data         = rd_data_reg;
        case (state_reg)
            plid_pkg::ST_IDLE: begin
                if (req_valid) begin
                    op_kind_next    = req.kind;
                    op_pos_next     = plid_pkg::CNT_W'(req.position);
                    op_word_next    = plid_pkg::field_to_word(req.value);
                    res_value_next  = '0;
                    res_status_next = req_status;
                    pend_next       = 1'b0;
                    left_next       = plid_pkg::CNT_W'(cnt_ext - pos_ext);
                    if (req.kind == plid_pkg::KIND_INSERT) begin
                        ptr_next = count_reg - plid_pkg::CNT_W'(1);
                    end else begin
                        ptr_next = plid_pkg::CNT_W'(req.position);
                        if (req.kind == plid_pkg::KIND_READ) begin
                            left_next = plid_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            plid_pkg::ST_SWEEP: begin
                if (pend_reg) begin
                    if (pend_cap_reg) begin
                        res_value_next = plid_pkg::word_to_field(rd_data_reg);
                    end else begin
                        wr_en = 1'b1;
                    end
                end
                if (left_reg != '0) begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    left_next     = left_reg - plid_pkg::CNT_W'(1);
                    pend_cap_next = (op_kind_reg != plid_pkg::KIND_INSERT) &&
                                    (ptr_reg == op_pos_reg);
                    if (op_kind_reg == plid_pkg::KIND_INSERT) begin
                        pend_addr_next = plid_pkg::ADDR_W'(ptr_reg + plid_pkg::CNT_W'(1));
                        ptr_next       = ptr_reg - plid_pkg::CNT_W'(1);
                    end else begin
                        pend_addr_next = plid_pkg::ADDR_W'(ptr_reg - plid_pkg::CNT_W'(1));
                        ptr_next       = ptr_reg + plid_pkg::CNT_W'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                    if (op_kind_reg == plid_pkg::KIND_DELETE) begin
                        count_next = count_reg - plid_pkg::CNT_W'(1);
                    end
                end
            end
            plid_pkg::ST_PLACE: begin
                wr_en      = 1'b1;
                wr_addr    = op_pos_reg[plid_pkg::ADDR_W-1:0];
                wr_data    = op_word_reg;
                count_next = count_reg + plid_pkg::CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= plid_pkg::ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_kind_reg    <= op_kind_next;
        op_pos_reg     <= op_pos_next;
        op_word_reg    <= op_word_next;
        ptr_reg        <= ptr_next;
        left_reg       <= left_next;
        pend_cap_reg   <= pend_cap_next;
        pend_addr_reg  <= pend_addr_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

endmodule

// ===== dv/list_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for positional_list_insert_delete: watches both stream channels, keeps its
// own copy of the list and count, and compares each returned beat field by field.
// Depends on plid_pkg.
module list_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [plid_pkg::S_TDATA_W-1:0] s_tdata,  // position[6:0], value[38:7], zero
    input  logic [plid_pkg::KIND_W-1:0]    s_tuser,  // kind[1:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [plid_pkg::M_TDATA_W-1:0] m_tdata,  // read_value[31:0], count[38:32],
                                                     // status[40:39], zero
    output int                             fail_count,
    output int                             pending,
    output int                             checked,
    output int                             full_refusals
);

    localparam int CNT_LSB  = plid_pkg::VAL_W;
    localparam int STAT_LSB = plid_pkg::VAL_W + plid_pkg::POS_W;
    localparam int PAD_LSB  = plid_pkg::VAL_W + plid_pkg::POS_W + plid_pkg::STAT_W;

    logic signed [plid_pkg::WIDTH-1:0] shadow_list [plid_pkg::DEPTH];
    int unsigned                       shadow_count;
    plid_pkg::res_t                    answer_q [$];
    int                                errors;
    int                                n_checked;
    int                                n_full;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic apply_request(input logic [plid_pkg::KIND_W-1:0] kind,
                                 input logic [plid_pkg::POS_W-1:0] pos,
                                 input logic signed [plid_pkg::VAL_W-1:0] val,
                                 output plid_pkg::res_t ans);
        int unsigned i;
        ans.read_value = '0;
        ans.status     = plid_pkg::STATUS_OK;
        case (kind)
            plid_pkg::KIND_INSERT: begin
                if (shadow_count >= plid_pkg::DEPTH) begin
                    ans.status = plid_pkg::STATUS_FULL;
                end else if (pos > shadow_count) begin
                    ans.status = plid_pkg::STATUS_RANGE;
                end else begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = val;
                    shadow_count++;
                end
            end
            plid_pkg::KIND_DELETE: begin
                if (pos >= shadow_count) begin
                    ans.status = plid_pkg::STATUS_RANGE;
                end else begin
                    ans.read_value = shadow_list[pos];
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
            end
            plid_pkg::KIND_READ: begin
                if (pos >= shadow_count) begin
                    ans.status = plid_pkg::STATUS_RANGE;
                end else begin
                    ans.read_value = shadow_list[pos];
                end
            end
            default: begin
                ans.status = plid_pkg::STATUS_RANGE;
            end
        endcase
        ans.count = plid_pkg::POS_W'(shadow_count);
    endtask

    always @(posedge aclk) begin
        plid_pkg::res_t seen;
        plid_pkg::res_t want;
        plid_pkg::res_t fresh;
        if (!aresetn) begin
            shadow_count = 0;
            answer_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen.read_value = m_tdata[0 +: plid_pkg::VAL_W];
                seen.count      = m_tdata[CNT_LSB +: plid_pkg::POS_W];
                seen.status     = plid_pkg::status_t'(m_tdata[STAT_LSB +: plid_pkg::STAT_W]);
                n_checked++;
                if (answer_q.size() == 0) begin
                    report_mismatch("beat with nothing outstanding", 64'(m_tdata), '0);
                end else begin
                    want = answer_q.pop_front();
                    if (seen.read_value !== want.read_value)
                        report_mismatch("read_value", 64'(unsigned'(seen.read_value)),
                                        64'(unsigned'(want.read_value)));
                    if (seen.count !== want.count)
                        report_mismatch("count", 64'(seen.count), 64'(want.count));
                    if (seen.status !== want.status)
                        report_mismatch("status", 64'(seen.status), 64'(want.status));
                    if (m_tdata[plid_pkg::M_TDATA_W-1:PAD_LSB] !== '0)
                        report_mismatch("padding", 64'(m_tdata[plid_pkg::M_TDATA_W-1:PAD_LSB]),
                                        '0);
                end
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata[0 +: plid_pkg::POS_W],
                              s_tdata[plid_pkg::POS_W +: plid_pkg::VAL_W], fresh);
                if (fresh.status == plid_pkg::STATUS_FULL)
                    n_full++;
                answer_q.push_back(fresh);
            end
        end
        fail_count    <= errors;
        pending       <= answer_q.size();
        checked       <= n_checked;
        full_refusals <= n_full;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Top of the positional_list_insert_delete testbench: clock, reset, request stimulus,
// random receiver stalls and the verdict. Depends on plid_pkg, list_result_checker and positional_list_insert_delete.
module tb;

    localparam logic [plid_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int N_RANDOM     = 650;
    localparam int DRAIN_CYCLES = 80;
    localparam int LIMIT_NS     = 20_000_000;
    localparam int MODE_GROW    = 0;
    localparam int MODE_MIX     = 1;
    localparam int MODE_SHRINK  = 2;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [plid_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [plid_pkg::KIND_W-1:0]     s_tuser  = '0;
    logic                            m_tready = 1'b0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic [plid_pkg::M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int pending;
    int checked;
    int full_refusals;
    int send_idle_pct = 37;
    int recv_idle_pct = 63;
    int fill = 0;
    int sent = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    positional_list_insert_delete i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_result_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .full_refusals (full_refusals)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_request(input logic [plid_pkg::KIND_W-1:0] kind,
                                input logic [plid_pkg::POS_W-1:0] pos,
                                input logic [plid_pkg::VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(plid_pkg::S_TDATA_W-plid_pkg::VAL_W-plid_pkg::POS_W){1'b0}}, val, pos};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent++;
        case (kind)
            plid_pkg::KIND_INSERT: if (fill < plid_pkg::DEPTH && pos <= fill) fill++;
            plid_pkg::KIND_DELETE: if (pos < fill) fill--;
            default: ;
        endcase
    endtask

    initial begin
        int mode;
        int seg_left;
        int r;
        logic [plid_pkg::KIND_W-1:0] kind;
        logic [plid_pkg::POS_W-1:0]  pos;
        logic [plid_pkg::VAL_W-1:0]  val;
        mode     = MODE_SHRINK;
        seg_left = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list, then edge values and middle shifts
        send_request(plid_pkg::KIND_READ,   7'd0,   32'h0000_0000);
        send_request(plid_pkg::KIND_DELETE, 7'd0,   32'h1234_5678);
        send_request(plid_pkg::KIND_INSERT, 7'd1,   32'h0000_0001);
        send_request(plid_pkg::KIND_INSERT, 7'd0,   32'h7FFF_FFFF);
        send_request(plid_pkg::KIND_INSERT, 7'd1,   32'h8000_0000);
        send_request(plid_pkg::KIND_INSERT, 7'd0,   32'hFFFF_FFFF);
        send_request(plid_pkg::KIND_INSERT, 7'd1,   32'h0000_0000);
        send_request(plid_pkg::KIND_INSERT, 7'd127, 32'h0000_0005);
        send_request(plid_pkg::KIND_READ,   7'd0,   32'hFFFF_FFFF);
        send_request(plid_pkg::KIND_READ,   7'd3,   32'h0000_0000);
        send_request(plid_pkg::KIND_READ,   7'd4,   32'h0000_0000);
        send_request(plid_pkg::KIND_READ,   7'd127, 32'h0000_0000);
        send_request(KIND_UNUSED,           7'd0,   32'hDEAD_BEEF);
        send_request(plid_pkg::KIND_DELETE, 7'd3,   32'h0000_0000);
        send_request(plid_pkg::KIND_DELETE, 7'd0,   32'h0000_0000);
        send_request(plid_pkg::KIND_INSERT, 7'd1,   32'h5555_5555);
        send_request(plid_pkg::KIND_INSERT, 7'd2,   32'hAAAA_AAAA);
        send_request(plid_pkg::KIND_READ,   7'd1,   32'h0000_0000);
        send_request(plid_pkg::KIND_READ,   7'd2,   32'h0000_0000);
        send_request(plid_pkg::KIND_DELETE, 7'd1,   32'h0000_0000);
        send_request(plid_pkg::KIND_DELETE, 7'd64,  32'h0000_0000);
        send_request(plid_pkg::KIND_DELETE, 7'd127, 32'h0000_0000);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 63;
                recv_idle_pct <= 37;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            if (seg_left == 0) begin
                mode     = (mode + 1) % 3;
                seg_left = $urandom_range(60, 110);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (r < 5)
                kind = KIND_UNUSED;
            else if (mode == MODE_GROW)
                kind = (r < 90) ? plid_pkg::KIND_INSERT :
                       (r < 95) ? plid_pkg::KIND_DELETE : plid_pkg::KIND_READ;
            else if (mode == MODE_MIX)
                kind = (r < 40) ? plid_pkg::KIND_INSERT :
                       (r < 70) ? plid_pkg::KIND_DELETE : plid_pkg::KIND_READ;
            else
                kind = (r < 10) ? plid_pkg::KIND_INSERT :
                       (r < 90) ? plid_pkg::KIND_DELETE : plid_pkg::KIND_READ;
            if ($urandom_range(0, 99) < 20)
                pos = $urandom_range(0, 127);
            else if (kind == plid_pkg::KIND_INSERT)
                pos = $urandom_range(0, fill);
            else
                pos = (fill == 0) ? 0 : $urandom_range(0, fill - 1);
            case ($urandom_range(0, 39))
                0:       val = 32'h0000_0000;
                1:       val = 32'hFFFF_FFFF;
                2:       val = 32'h7FFF_FFFF;
                3:       val = 32'h8000_0000;
                default: val = $urandom;
            endcase
            send_request(kind, pos, val);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests under three stall patterns, list filled and emptied",
                 sent);
        $display("%0d result beats checked, %0d inserts refused on a full list",
                 checked, full_refusals);
        if (fail_count == 0) begin
            $display("positional_list_insert_delete regression: pass");
        end else begin
            $display("positional_list_insert_delete regression: fail");
        end
        $finish;
    end

    initial begin
        #LIMIT_NS;
        $display("timeout with %0d results outstanding", pending);
        $display("positional_list_insert_delete regression: fail");
        $finish;
    end

endmodule
